// File: hdl/fet_pkg.sv
// Shared types, constants and helpers of the escape-time fractal iterator.
// Used by fet_mul_cell, fet_power_chain and fractal_escape_time_iterator_unit.
package fet_pkg;

  localparam int FRAC_BITS      = 28;
  localparam int FX_W           = 32;
  localparam int RAW_W          = 2 * FX_W - FRAC_BITS;
  localparam int WIDE_W         = 48;
  localparam int MAX_ITERATIONS = 256;
  localparam int COORD_BITS     = 10;
  localparam int COUNT_W        = 9;
  localparam int MODE_W         = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int STEP_W         = 31;

  localparam logic [MODE_W-1:0] MODE_SQUARE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIFTH      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIFTH_NEG  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd4;

  localparam logic signed [WIDE_W-1:0] FX_MAX_W = 48'sd2147483647;
  localparam logic signed [WIDE_W-1:0] FX_MIN_W = -48'sd2147483648;
  localparam logic signed [RAW_W:0]    ESCAPE_LIMIT = 37'sd4 <<< FRAC_BITS;

  // Products of one iteration, as seen by the update logic.
  typedef struct packed {
    logic signed [RAW_W-1:0] a2_raw;
    logic signed [RAW_W-1:0] b2_raw;
    logic signed [FX_W-1:0]  a2;
    logic signed [FX_W-1:0]  b2;
    logic signed [FX_W-1:0]  ab;
    logic signed [FX_W-1:0]  a5;
    logic signed [FX_W-1:0]  b5;
    logic signed [FX_W-1:0]  a3b2;
    logic signed [FX_W-1:0]  ab4;
    logic signed [FX_W-1:0]  a4b;
    logic signed [FX_W-1:0]  a2b3;
  } fet_prod_t;

  function automatic logic signed [FX_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [FX_W-1:0] r;
    if (v > FX_MAX_W) begin
      r = FX_MAX_W[FX_W-1:0];
    end else if (v < FX_MIN_W) begin
      r = FX_MIN_W[FX_W-1:0];
    end else begin
      r = v[FX_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/fet_mul_cell.sv
// One multiply cell: registered floor product of two Q4.28 values.
// Gives the unsaturated floored product and its 32-bit saturated form. Uses fet_pkg.
module fet_mul_cell import fet_pkg::*; (
  input  logic                    clk,
  input  logic signed [FX_W-1:0]  a,
  input  logic signed [FX_W-1:0]  b,
  output logic signed [FX_W-1:0]  prod,
  output logic signed [RAW_W-1:0] prod_raw
);

  logic signed [2*FX_W-1:0] full;
  logic signed [RAW_W-1:0]  raw_next;

  // Taking the upper bits of a two's complement product floors it.
  assign full     = a * b;
  assign raw_next = full[2*FX_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    prod_raw <= raw_next;
    prod     <= sat32(WIDE_W'(raw_next));
  end

endmodule

// File: hdl/fet_power_chain.sv
// Row of multiply cells in three ranks that builds the powers of z for one iteration.
// Each rank feeds the next through its registered products. Uses fet_pkg and fet_mul_cell.
module fet_power_chain import fet_pkg::*; (
  input  logic                   clk,
  input  logic signed [FX_W-1:0] re,
  input  logic signed [FX_W-1:0] im,
  output fet_prod_t              prods
);

  logic signed [FX_W-1:0] a2, b2, ab, a3, b3, a4, b4;

  // First rank: squares and cross product; the raw forms of the squares drive the escape test.
  fet_mul_cell u_a2 (.clk(clk), .a(re), .b(re), .prod(a2), .prod_raw(prods.a2_raw));
  fet_mul_cell u_b2 (.clk(clk), .a(im), .b(im), .prod(b2), .prod_raw(prods.b2_raw));
  fet_mul_cell u_ab (.clk(clk), .a(re), .b(im), .prod(ab), .prod_raw());

  // Second rank: cubes and fourth powers.
  fet_mul_cell u_a3 (.clk(clk), .a(a2), .b(re), .prod(a3), .prod_raw());
  fet_mul_cell u_b3 (.clk(clk), .a(b2), .b(im), .prod(b3), .prod_raw());
  fet_mul_cell u_a4 (.clk(clk), .a(a2), .b(a2), .prod(a4), .prod_raw());
  fet_mul_cell u_b4 (.clk(clk), .a(b2), .b(b2), .prod(b4), .prod_raw());

  // Third rank: the fifth-degree terms.
  fet_mul_cell u_a5   (.clk(clk), .a(a4), .b(re), .prod(prods.a5),   .prod_raw());
  fet_mul_cell u_b5   (.clk(clk), .a(b4), .b(im), .prod(prods.b5),   .prod_raw());
  fet_mul_cell u_a3b2 (.clk(clk), .a(a3), .b(b2), .prod(prods.a3b2), .prod_raw());
  fet_mul_cell u_ab4  (.clk(clk), .a(re), .b(b4), .prod(prods.ab4),  .prod_raw());
  fet_mul_cell u_a4b  (.clk(clk), .a(a4), .b(im), .prod(prods.a4b),  .prod_raw());
  fet_mul_cell u_a2b3 (.clk(clk), .a(a2), .b(b3), .prod(prods.a2b3), .prod_raw());

  assign prods.a2 = a2;
  assign prods.b2 = b2;
  assign prods.ab = ab;

endmodule

// File: hdl/fractal_escape_time_iterator_unit.sv
// Top level of the escape-time fractal iterator: control, mapping of c and z update.
// Depends on fet_pkg and fet_power_chain.
//
// One pixel word (column, row) is taken at a time. The pixel is mapped to
// c = origin + coordinate * step in the map state, then z starts at zero and is
// iterated until |z|^2 reaches 4.0 or the limit (max_iterations, clamped to 256)
// is reached. Each iteration passes the check state for the limit test and
// then the states of the multiply cell ranks: state P1 only in the tricorn mode,
// states P1, P2 and P3 in the fifth-power modes. Around the iterations, the
// map state maps c, the check state does the final limit check and the done
// state hands the result word over. A pixel that escapes ends instead with
// its last magnitude test in state P1. The result sits in an output
// register, so a new pixel is accepted while the previous result word still
// waits to be taken.
// Configuration should only be written while the unit is idle.
module fractal_escape_time_iterator_unit import fet_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [COORD_BITS-1:0]       column,
  input  logic [COORD_BITS-1:0]       row,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [COORD_BITS-1:0]       out_column,
  output logic [COORD_BITS-1:0]       out_row,
  output logic [COUNT_W-1:0]          iteration_count,
  output logic                        escaped
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAP   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_P1    = 3'd3;
  localparam logic [2:0] ST_P2    = 3'd4;
  localparam logic [2:0] ST_P3    = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  // Configuration registers.
  logic [MODE_W-1:0]       mode;
  logic [COUNT_W-1:0]      max_iterations;
  logic signed [FX_W-1:0]  origin_re;
  logic signed [FX_W-1:0]  origin_im;
  logic [STEP_W-1:0]       step;

  // Per-pixel state.
  logic [2:0]              state;
  logic [COORD_BITS-1:0]   col_r;
  logic [COORD_BITS-1:0]   row_r;
  logic [COUNT_W-1:0]      limit;
  logic [COUNT_W-1:0]      count;
  logic                    esc;
  logic signed [FX_W-1:0]  cr;
  logic signed [FX_W-1:0]  ci;
  logic signed [FX_W-1:0]  re;
  logic signed [FX_W-1:0]  im;

  fet_prod_t               prods;

  logic signed [WIDE_W-1:0] map_re, map_im;
  logic signed [RAW_W:0]    mag;
  logic                     fifth;
  logic signed [FX_W-1:0]   sq_r, sq_im, fi_r, fi_im;
  logic signed [FX_W-1:0]   re_next, im_next;
  logic                     out_free;

  fet_power_chain u_chain (
    .clk   (clk),
    .re    (re),
    .im    (im),
    .prods (prods)
  );

  // Pixel to plane mapping: exact product and sum, saturated once.
  assign map_re = WIDE_W'(origin_re) +
                  $signed({{(WIDE_W-COORD_BITS){1'b0}}, col_r}) *
                  $signed({{(WIDE_W-STEP_W){1'b0}}, step});
  assign map_im = WIDE_W'(origin_im) +
                  $signed({{(WIDE_W-COORD_BITS){1'b0}}, row_r}) *
                  $signed({{(WIDE_W-STEP_W){1'b0}}, step});

  // Escape test uses the floored squares without saturation.
  assign mag   = (RAW_W+1)'(prods.a2_raw) + (RAW_W+1)'(prods.b2_raw);
  assign fifth = (mode == MODE_FIFTH) || (mode == MODE_FIFTH_NEG);

  // Tricorn step: real part negated after the square plus c.
  assign sq_r  = sat32(WIDE_W'(prods.a2) - WIDE_W'(prods.b2) + WIDE_W'(cr));
  assign sq_im = sat32((WIDE_W'(prods.ab) <<< 1) + WIDE_W'(ci));

  // Fifth power expanded with binomial weights 1, 5 and 10.
  assign fi_r  = sat32(WIDE_W'(prods.a5) - WIDE_W'(prods.a3b2) * 48'sd10
                       + WIDE_W'(prods.ab4) * 48'sd5 + WIDE_W'(cr));
  assign fi_im = sat32(WIDE_W'(prods.a4b) * 48'sd5 - WIDE_W'(prods.a2b3) * 48'sd10
                       + WIDE_W'(prods.b5) + WIDE_W'(ci));

  always_comb begin
    if (!fifth) begin
      re_next = sat32(-WIDE_W'(sq_r));
      im_next = sq_im;
    end else if (mode == MODE_FIFTH_NEG) begin
      re_next = sat32(-WIDE_W'(fi_r));
      im_next = fi_im;
    end else begin
      re_next = fi_r;
      im_next = fi_im;
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_SQUARE;
      max_iterations <= COUNT_W'(64);
      origin_re      <= -32'sd536870912;
      origin_im      <= -32'sd536870912;
      step           <= STEP_W'(1048576);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:      mode           <= cfg_data[MODE_W-1:0];
        REG_MAX_ITER:  max_iterations <= cfg_data[COUNT_W-1:0];
        REG_ORIGIN_RE: origin_re      <= cfg_data;
        REG_ORIGIN_IM: origin_im      <= cfg_data;
        REG_STEP:      step           <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Iteration sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The done state loads the next word itself, so the word is only
      // released here in the other states.
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            col_r <= column;
            row_r <= row;
            limit <= (max_iterations > COUNT_W'(MAX_ITERATIONS)) ?
                     COUNT_W'(MAX_ITERATIONS) : max_iterations;
            state <= ST_MAP;
          end
        end
        ST_MAP: begin
          cr    <= sat32(map_re);
          ci    <= sat32(map_im);
          re    <= '0;
          im    <= '0;
          count <= '0;
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (count >= limit) begin
            esc   <= 1'b0;
            state <= ST_DONE;
          end else begin
            state <= ST_P1;
          end
        end
        ST_P1: begin
          if (mag >= ESCAPE_LIMIT) begin
            esc   <= 1'b1;
            state <= ST_DONE;
          end else if (!fifth) begin
            re    <= re_next;
            im    <= im_next;
            count <= count + 1'b1;
            state <= ST_CHECK;
          end else begin
            state <= ST_P2;
          end
        end
        ST_P2: begin
          state <= ST_P3;
        end
        ST_P3: begin
          re    <= re_next;
          im    <= im_next;
          count <= count + 1'b1;
          state <= ST_CHECK;
        end
        ST_DONE: begin
          if (out_free) begin
            out_column      <= col_r;
            out_row         <= row_r;
            iteration_count <= count;
            escaped         <= esc;
            out_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The running count never passes the clamped limit.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK || state == ST_P1) |-> (count <= limit))
    else $error("iteration count passed the limit");

  // A fresh result word only comes out of the done state.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result word loaded outside the done state");

  // An escaped pixel stopped before the iteration cap.
  a_escape_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && escaped) |-> (iteration_count < COUNT_W'(MAX_ITERATIONS)))
    else $error("escaped pixel reports a full iteration count");

  // The limit is clamped when a pixel starts.
  a_limit_clamp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> (limit <= COUNT_W'(MAX_ITERATIONS)))
    else $error("iteration limit not clamped");

endmodule
